@@ rtl/transaction_wire_parser_top_defines.svh @@
// Assertion macros used by the parser state logic (twp_step).
`ifndef TRANSACTION_WIRE_PARSER_TOP_DEFINES_SVH
`define TRANSACTION_WIRE_PARSER_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its condition.
`define TWP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its condition.
`define TWP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/twp_pkg.sv @@
// Types and constants shared by the transaction wire parser.
package twp_pkg;

	localparam int unsigned KEY_BYTES = 32;
	localparam int unsigned SIG_BYTES = 64;

	localparam logic [7:0] VARINT_MASK = 8'h7F;
	localparam logic [7:0] VARINT_MORE = 8'h80;
	localparam logic [7:0] VARINT_TOP  = 8'h03;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TRUNC    = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef enum logic [3:0] {
		PH_SIGCOUNT   = 4'd0,
		PH_SIG        = 4'd1,
		PH_HDR0       = 4'd2,
		PH_HDR1       = 4'd3,
		PH_HDR2       = 4'd4,
		PH_KEYCOUNT   = 4'd5,
		PH_KEY        = 4'd6,
		PH_BLOCKHASH  = 4'd7,
		PH_INSTRCOUNT = 4'd8,
		PH_PROGIDX    = 4'd9,
		PH_ACCTCOUNT  = 4'd10,
		PH_ACCTIDX    = 4'd11,
		PH_DATALEN    = 4'd12,
		PH_DATA       = 4'd13,
		PH_TRAILING   = 4'd14,
		PH_DISCARD    = 4'd15
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_buffer;
	} byte_req_t;

	typedef struct packed {
		logic [3:0]  byte_kind;
		logic [15:0] item_number;
		logic [15:0] byte_offset;
		logic [15:0] count_value;
		logic        count_valid;
		logic [1:0]  status;
		logic        message_done;
	} label_req_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] acc;
		logic [1:0]  vpos;
		logic [15:0] items_left;
		logic [15:0] field_left;
		logic [15:0] item_cnt;
		logic [15:0] byte_cnt;
		logic        err;
		logic        done;
	} parse_state_t;

endpackage

@@ rtl/transaction_wire_parser_top.sv @@
// Top level of the byte-serial transaction wire parser.
//
//  channel   direction  handshake               payload
//  byte      input      byte_valid/byte_stall   byte_data  (twp_pkg::byte_req_t)
//  label     output     label_valid/label_stall label_data (twp_pkg::label_req_t)
//  cfg       input      cfg_we                  cfg_wdata  (with_signatures)
//
// One byte per cycle unless label_stall holds; labels pass input and result registers.
// The rate is set by the single parser state register, updated once per byte.
// Reset (arst_n low) selects full-transaction mode and starts a new buffer.
// A stall on the label side holds the result register and backs up into byte_stall.
// A cfg write restarts the parser in the new mode.
module transaction_wire_parser_top #(
	parameter int unsigned KEY_SIZE = twp_pkg::KEY_BYTES,
	parameter int unsigned SIG_SIZE = twp_pkg::SIG_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  twp_pkg::byte_req_t  byte_data,
	output logic                label_valid,
	input  logic                label_stall,
	output twp_pkg::label_req_t label_data,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);
	import twp_pkg::*;

	logic       advance;
	logic       valid_s1;
	logic       fire;
	byte_req_t  data_s1;
	label_req_t res;

	assign fire = valid_s1 && advance;

	twp_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1)
	);

	twp_step #(
		.KEY_SIZE (KEY_SIZE),
		.SIG_SIZE (SIG_SIZE)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.data_s1   (data_s1),
		.res       (res)
	);

	twp_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.res         (res),
		.advance     (advance),
		.label_valid (label_valid),
		.label_stall (label_stall),
		.label_data  (label_data)
	);

endmodule

@@ rtl/twp_in_stage.sv @@
// Input register stage: captures one byte request per cycle while byte_stall is low.
module twp_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  twp_pkg::byte_req_t byte_data,
	input  logic               advance,
	output logic               valid_s1,
	output twp_pkg::byte_req_t data_s1
);
	import twp_pkg::*;

	logic vld_s1;

	assign byte_stall = vld_s1 && !advance;
	assign valid_s1   = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!byte_stall) begin
			vld_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			data_s1 <= byte_data;
		end
	end

endmodule

@@ rtl/twp_step.sv @@
// Parser state and the per-byte labelling logic.
module twp_step #(
	parameter int unsigned KEY_SIZE = twp_pkg::KEY_BYTES,
	parameter int unsigned SIG_SIZE = twp_pkg::SIG_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                fire,
	input  twp_pkg::byte_req_t  data_s1,
	output twp_pkg::label_req_t res
);
	import twp_pkg::*;
	`include "transaction_wire_parser_top_defines.svh"

	localparam logic [15:0] KEY_LEN = 16'(KEY_SIZE);
	localparam logic [15:0] SIG_LEN = 16'(SIG_SIZE);

	parse_state_t state_q;
	parse_state_t nx;
	logic         with_sig_q;

	function automatic parse_state_t restart(input logic with_sig);
		parse_state_t s;
		s       = '0;
		s.phase = with_sig ? PH_SIGCOUNT : PH_HDR0;
		return s;
	endfunction

	function automatic parse_state_t finish_msg(input parse_state_t s);
		parse_state_t r;
		r          = s;
		r.done     = 1'b1;
		r.phase    = PH_TRAILING;
		r.byte_cnt = '0;
		return r;
	endfunction

	function automatic parse_state_t end_instr(input parse_state_t s);
		parse_state_t r;
		r            = s;
		r.item_cnt   = s.item_cnt + 16'd1;
		r.items_left = s.items_left - 16'd1;
		if (r.items_left == '0) begin
			r = finish_msg(r);
		end else begin
			r.phase = PH_PROGIDX;
		end
		return r;
	endfunction

	always_comb begin
		logic [7:0]  b;
		logic        vdone;
		logic        vovf;
		logic [15:0] n;

		b     = data_s1.in_byte;
		nx    = state_q;
		res   = '0;
		vdone = 1'b0;
		vovf  = 1'b0;
		n     = '0;
		res.byte_kind = state_q.phase;

		unique case (state_q.phase)
			PH_SIGCOUNT, PH_KEYCOUNT, PH_INSTRCOUNT, PH_ACCTCOUNT, PH_DATALEN: begin
				res.byte_offset = {14'd0, state_q.vpos};
				if (state_q.phase == PH_ACCTCOUNT || state_q.phase == PH_DATALEN) begin
					res.item_number = state_q.item_cnt;
				end
				case (state_q.vpos)
					2'd0: begin
						nx.acc = {8'd0, b & VARINT_MASK};
						if (b < VARINT_MORE) begin
							vdone = 1'b1;
						end else begin
							nx.vpos = 2'd1;
						end
					end
					2'd1: begin
						nx.acc = state_q.acc | {2'd0, b[6:0], 7'd0};
						if (b < VARINT_MORE) begin
							nx.vpos = 2'd0;
							vdone   = 1'b1;
						end else begin
							nx.vpos = 2'd2;
						end
					end
					default: begin
						nx.vpos = 2'd0;
						if (b > VARINT_TOP) begin
							vovf = 1'b1;
						end else begin
							nx.acc = state_q.acc | {b[1:0], 14'd0};
							vdone  = 1'b1;
						end
					end
				endcase
				n = nx.acc;
				if (vovf) begin
					res.status = ST_OVERFLOW;
					nx.err     = 1'b1;
					nx.phase   = PH_DISCARD;
				end else if (vdone) begin
					res.count_valid = 1'b1;
					res.count_value = n;
					case (state_q.phase)
						PH_SIGCOUNT: begin
							nx.items_left = n;
							nx.item_cnt   = '0;
							if (n != '0) begin
								nx.phase      = PH_SIG;
								nx.field_left = SIG_LEN;
								nx.byte_cnt   = '0;
							end else begin
								nx.phase = PH_HDR0;
							end
						end
						PH_KEYCOUNT: begin
							nx.items_left = n;
							nx.item_cnt   = '0;
							nx.field_left = KEY_LEN;
							nx.byte_cnt   = '0;
							nx.phase      = (n != '0) ? PH_KEY : PH_BLOCKHASH;
						end
						PH_INSTRCOUNT: begin
							nx.items_left = n;
							nx.item_cnt   = '0;
							if (n != '0) begin
								nx.phase = PH_PROGIDX;
							end else begin
								nx = finish_msg(nx);
							end
						end
						PH_ACCTCOUNT: begin
							if (n != '0) begin
								nx.phase      = PH_ACCTIDX;
								nx.field_left = n;
								nx.byte_cnt   = '0;
							end else begin
								nx.phase = PH_DATALEN;
							end
						end
						default: begin
							if (n != '0) begin
								nx.phase      = PH_DATA;
								nx.field_left = n;
								nx.byte_cnt   = '0;
							end else begin
								nx = end_instr(nx);
							end
						end
					endcase
				end
			end
			PH_SIG, PH_KEY: begin
				res.item_number = state_q.item_cnt;
				res.byte_offset = state_q.byte_cnt;
				nx.byte_cnt     = state_q.byte_cnt + 16'd1;
				nx.field_left   = state_q.field_left - 16'd1;
				if (nx.field_left == '0) begin
					nx.item_cnt   = state_q.item_cnt + 16'd1;
					nx.items_left = state_q.items_left - 16'd1;
					nx.byte_cnt   = '0;
					if (nx.items_left != '0) begin
						nx.field_left = (state_q.phase == PH_SIG) ? SIG_LEN : KEY_LEN;
					end else if (state_q.phase == PH_SIG) begin
						nx.phase = PH_HDR0;
					end else begin
						nx.phase      = PH_BLOCKHASH;
						nx.field_left = KEY_LEN;
					end
				end
			end
			PH_HDR0: nx.phase = PH_HDR1;
			PH_HDR1: nx.phase = PH_HDR2;
			PH_HDR2: nx.phase = PH_KEYCOUNT;
			PH_BLOCKHASH: begin
				res.byte_offset = state_q.byte_cnt;
				nx.byte_cnt     = state_q.byte_cnt + 16'd1;
				nx.field_left   = state_q.field_left - 16'd1;
				if (nx.field_left == '0) begin
					nx.phase = PH_INSTRCOUNT;
				end
			end
			PH_PROGIDX: begin
				res.item_number = state_q.item_cnt;
				nx.phase        = PH_ACCTCOUNT;
			end
			PH_ACCTIDX, PH_DATA: begin
				res.item_number = state_q.item_cnt;
				res.byte_offset = state_q.byte_cnt;
				nx.byte_cnt     = state_q.byte_cnt + 16'd1;
				nx.field_left   = state_q.field_left - 16'd1;
				if (nx.field_left == '0) begin
					if (state_q.phase == PH_ACCTIDX) begin
						nx.phase = PH_DATALEN;
					end else begin
						nx = end_instr(nx);
					end
				end
			end
			PH_TRAILING: begin
				res.byte_offset = state_q.byte_cnt;
				nx.byte_cnt     = state_q.byte_cnt + 16'd1;
			end
			PH_DISCARD: begin
				res.byte_kind = PH_DISCARD;
			end
		endcase

		// completion is only ever set by the finishing path
		res.message_done = nx.done && !state_q.done;

		if (data_s1.end_of_buffer) begin
			if (!nx.done && !nx.err) begin
				res.status = ST_TRUNC;
			end
			nx = restart(with_sig_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			with_sig_q <= 1'b1;
			state_q    <= restart(1'b1);
		end else if (cfg_we) begin
			with_sig_q <= cfg_wdata;
			state_q    <= restart(cfg_wdata);
		end else if (fire) begin
			state_q <= nx;
		end
	end

	`TWP_ASSERT_NEXT(a_eob_restart, fire && data_s1.end_of_buffer,
		state_q.phase == (with_sig_q ? PH_SIGCOUNT : PH_HDR0) && state_q.byte_cnt == '0,
		"parser did not restart after buffer end")
	`TWP_ASSERT_SAME(a_err_discard, state_q.err, state_q.phase == PH_DISCARD,
		"overflow latched outside discard phase")
	`TWP_ASSERT_SAME(a_count_no_ovf, fire, !(res.count_valid && res.status == ST_OVERFLOW),
		"count completed on an overflowing byte")
	`TWP_ASSERT_NEXT(a_done_trailing,
		fire && res.message_done && !data_s1.end_of_buffer && !cfg_we,
		state_q.phase == PH_TRAILING && state_q.done,
		"message completion did not enter trailing phase")

endmodule

@@ rtl/twp_out_stage.sv @@
// Result register stage: holds one labelled byte until taken.
module twp_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  twp_pkg::label_req_t res,
	output logic                advance,
	output logic                label_valid,
	input  logic                label_stall,
	output twp_pkg::label_req_t label_data
);
	import twp_pkg::*;

	logic       valid_s2;
	label_req_t data_s2;

	// free when empty or when the held request leaves this cycle
	assign advance     = !valid_s2 || !label_stall;
	assign label_valid = valid_s2;
	assign label_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			data_s2 <= res;
		end
	end

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the transaction wire parser: every byte label is checked in order.
`timescale 1ns / 100ps

module tb;
	import twp_pkg::*;

	localparam int DIR_ROWS     = 24;
	localparam int PHASES       = 8;
	localparam int PHASE_BYTES  = 120;
	localparam int DRAIN_CYCLES = 6;
	localparam int LONG_HOLD    = 300;
	localparam int TIMEOUT_NS   = 3_000_000;

	localparam int VI_MORE     = 0;
	localparam int VI_DONE     = 1;
	localparam int VI_OVERFLOW = 2;

	localparam logic [15:0] SIG_LEN = 16'(SIG_BYTES);
	localparam logic [15:0] KEY_LEN = 16'(KEY_BYTES);

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [7:0] value;
		logic       last;
		logic       typed;
		label_req_t label;
	} dir_row_t;

	localparam label_req_t NO_LABEL = '0;

	// Rows with a typed label are checked against that label; the rest use the predictor.
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// empty signature section, then a header cut short
		'{ROW_BYTE, 8'h00, 1'b0, 1'b1, '{PH_SIGCOUNT, 16'd0, 16'd0, 16'd0, 1'b1, ST_OK, 1'b0}},
		'{ROW_BYTE, 8'hAA, 1'b0, 1'b0, NO_LABEL},
		'{ROW_BYTE, 8'h55, 1'b0, 1'b0, NO_LABEL},
		'{ROW_BYTE, 8'hFF, 1'b1, 1'b1, '{PH_HDR2, 16'd0, 16'd0, 16'd0, 1'b0, ST_TRUNC, 1'b0}},
		// count overflow, then discarded bytes up to the buffer end
		'{ROW_BYTE, 8'hFF, 1'b0, 1'b0, NO_LABEL},
		'{ROW_BYTE, 8'hFF, 1'b0, 1'b0, NO_LABEL},
		'{ROW_BYTE, 8'h04, 1'b0, 1'b1,
			'{PH_SIGCOUNT, 16'd0, 16'd2, 16'd0, 1'b0, ST_OVERFLOW, 1'b0}},
		'{ROW_BYTE, 8'h00, 1'b0, 1'b1, '{PH_DISCARD, 16'd0, 16'd0, 16'd0, 1'b0, ST_OK, 1'b0}},
		'{ROW_BYTE, 8'h7F, 1'b1, 1'b1, '{PH_DISCARD, 16'd0, 16'd0, 16'd0, 1'b0, ST_OK, 1'b0}},
		// largest count, truncated inside the first signature
		'{ROW_BYTE, 8'hFF, 1'b0, 1'b0, NO_LABEL},
		'{ROW_BYTE, 8'hFF, 1'b0, 1'b0, NO_LABEL},
		'{ROW_BYTE, 8'h03, 1'b0, 1'b1,
			'{PH_SIGCOUNT, 16'd0, 16'd2, 16'hFFFF, 1'b1, ST_OK, 1'b0}},
		'{ROW_BYTE, 8'h80, 1'b0, 1'b0, NO_LABEL},
		'{ROW_BYTE, 8'h01, 1'b1, 1'b1, '{PH_SIG, 16'd0, 16'd1, 16'd0, 1'b0, ST_TRUNC, 1'b0}},
		// bare message, zero keys in a padded count, cut in the blockhash
		'{ROW_CFG, 8'h00, 1'b0, 1'b0, NO_LABEL},
		'{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_LABEL},
		'{ROW_BYTE, 8'hFF, 1'b0, 1'b0, NO_LABEL},
		'{ROW_BYTE, 8'h80, 1'b0, 1'b0, NO_LABEL},
		'{ROW_BYTE, 8'h80, 1'b0, 1'b0, NO_LABEL},
		'{ROW_BYTE, 8'h00, 1'b0, 1'b1,
			'{PH_KEYCOUNT, 16'd0, 16'd1, 16'd0, 1'b1, ST_OK, 1'b0}},
		'{ROW_BYTE, 8'h5A, 1'b1, 1'b1,
			'{PH_BLOCKHASH, 16'd0, 16'd0, 16'd0, 1'b0, ST_TRUNC, 1'b0}},
		'{ROW_CFG, 8'h01, 1'b0, 1'b0, NO_LABEL},
		'{ROW_BYTE, 8'h01, 1'b0, 1'b0, NO_LABEL},
		'{ROW_BYTE, 8'h00, 1'b1, 1'b0, NO_LABEL}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_stall;
	byte_req_t  byte_data;
	logic       label_valid;
	logic       label_stall;
	label_req_t label_data;
	logic       cfg_we;
	logic       cfg_wdata;

	transaction_wire_parser_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.label_valid(label_valid),
		.label_stall(label_stall),
		.label_data (label_data),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Parser state mirrored by the predictor
	logic        sig_mode;
	phase_t      ph;
	logic [15:0] acc;
	logic [1:0]  vpos;
	logic [15:0] items_left;
	logic [15:0] field_left;
	logic [15:0] item_cnt;
	logic [15:0] byte_cnt;
	logic        err_seen;
	logic        msg_done;

	label_req_t  pending_labels[$];
	logic [7:0]  buf_bytes[$];
	int          count_spots[$];
	int          mismatches;
	int          items_sent;
	int          burst_left;
	logic        gaps_on;
	logic        hold_req;

	task automatic restart_parse();
		ph = sig_mode ? PH_SIGCOUNT : PH_HDR0;
		acc = '0;
		vpos = '0;
		items_left = '0;
		field_left = '0;
		item_cnt = '0;
		byte_cnt = '0;
		err_seen = 1'b0;
		msg_done = 1'b0;
	endtask

	function automatic int varint_step(input logic [7:0] b);
		int res;
		res = VI_MORE;
		case (vpos)
			2'd0: begin
				acc = 16'(b & VARINT_MASK);
				if ((b & VARINT_MORE) == 8'd0) res = VI_DONE;
				else vpos = 2'd1;
			end
			2'd1: begin
				acc = acc | (16'(b & VARINT_MASK) << 7);
				if ((b & VARINT_MORE) == 8'd0) begin
					vpos = 2'd0;
					res = VI_DONE;
				end else begin
					vpos = 2'd2;
				end
			end
			default: begin
				vpos = 2'd0;
				if (b > VARINT_TOP) begin
					res = VI_OVERFLOW;
				end else begin
					acc = acc | (16'(b) << 14);
					res = VI_DONE;
				end
			end
		endcase
		return res;
	endfunction

	task automatic open_field(input phase_t p, input logic [15:0] len);
		ph = p;
		field_left = len;
		byte_cnt = '0;
	endtask

	function automatic logic field_step(output logic [15:0] off);
		off = byte_cnt;
		byte_cnt = byte_cnt + 16'd1;
		field_left = field_left - 16'd1;
		return field_left == 16'd0;
	endfunction

	function automatic void close_message();
		msg_done = 1'b1;
		ph = PH_TRAILING;
		byte_cnt = '0;
	endfunction

	// Advance to the next instruction; report whether the message just ended.
	function automatic logic next_instruction();
		item_cnt = item_cnt + 16'd1;
		items_left = items_left - 16'd1;
		if (items_left == 16'd0) begin
			close_message();
			return 1'b1;
		end
		ph = PH_PROGIDX;
		return 1'b0;
	endfunction

	task automatic predict_label(input byte_req_t req, output label_req_t lab);
		logic [15:0] n;
		logic [15:0] off;
		logic        last;
		int          r;
		lab = '0;
		lab.byte_kind = ph;
		case (ph)
			PH_SIGCOUNT, PH_KEYCOUNT, PH_INSTRCOUNT, PH_ACCTCOUNT, PH_DATALEN: begin
				lab.byte_offset = 16'(vpos);
				if (ph == PH_ACCTCOUNT || ph == PH_DATALEN) lab.item_number = item_cnt;
				r = varint_step(req.in_byte);
				if (r == VI_OVERFLOW) begin
					lab.status = ST_OVERFLOW;
					err_seen = 1'b1;
					ph = PH_DISCARD;
				end else if (r == VI_DONE) begin
					n = acc;
					lab.count_valid = 1'b1;
					lab.count_value = n;
					case (ph)
						PH_SIGCOUNT: begin
							items_left = n;
							item_cnt = '0;
							if (n != 16'd0) open_field(PH_SIG, SIG_LEN);
							else ph = PH_HDR0;
						end
						PH_KEYCOUNT: begin
							items_left = n;
							item_cnt = '0;
							if (n != 16'd0) open_field(PH_KEY, KEY_LEN);
							else open_field(PH_BLOCKHASH, KEY_LEN);
						end
						PH_INSTRCOUNT: begin
							items_left = n;
							item_cnt = '0;
							if (n != 16'd0) begin
								ph = PH_PROGIDX;
							end else begin
								close_message();
								lab.message_done = 1'b1;
							end
						end
						PH_ACCTCOUNT: begin
							if (n != 16'd0) open_field(PH_ACCTIDX, n);
							else ph = PH_DATALEN;
						end
						default: begin
							if (n != 16'd0) open_field(PH_DATA, n);
							else lab.message_done = next_instruction();
						end
					endcase
				end
			end
			PH_SIG, PH_KEY: begin
				lab.item_number = item_cnt;
				last = field_step(off);
				lab.byte_offset = off;
				if (last) begin
					item_cnt = item_cnt + 16'd1;
					items_left = items_left - 16'd1;
					if (items_left != 16'd0) open_field(ph, ph == PH_SIG ? SIG_LEN : KEY_LEN);
					else if (ph == PH_SIG) ph = PH_HDR0;
					else open_field(PH_BLOCKHASH, KEY_LEN);
				end
			end
			PH_HDR0: ph = PH_HDR1;
			PH_HDR1: ph = PH_HDR2;
			PH_HDR2: ph = PH_KEYCOUNT;
			PH_BLOCKHASH: begin
				last = field_step(off);
				lab.byte_offset = off;
				if (last) ph = PH_INSTRCOUNT;
			end
			PH_PROGIDX: begin
				lab.item_number = item_cnt;
				ph = PH_ACCTCOUNT;
			end
			PH_ACCTIDX: begin
				lab.item_number = item_cnt;
				last = field_step(off);
				lab.byte_offset = off;
				if (last) ph = PH_DATALEN;
			end
			PH_DATA: begin
				lab.item_number = item_cnt;
				last = field_step(off);
				lab.byte_offset = off;
				if (last) lab.message_done = next_instruction();
			end
			PH_TRAILING: begin
				lab.byte_offset = byte_cnt;
				byte_cnt = byte_cnt + 16'd1;
			end
			default: lab.byte_kind = PH_DISCARD;
		endcase
		if (req.end_of_buffer) begin
			if (!msg_done && !err_seen) lab.status = ST_TRUNC;
			restart_parse();
		end
	endtask

	// Offer one request, hold it until accepted, then record its expected label.
	task automatic send_byte(input byte_req_t req, input logic typed, input label_req_t typed_lab);
		label_req_t lab;
		int         gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
				: $urandom_range(1, 5);
		end
		burst_left--;
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= req;
		do @(posedge clk); while (byte_stall);
		predict_label(req, lab);
		pending_labels = {pending_labels, typed ? typed_lab : lab};
		items_sent++;
	endtask

	task automatic send_buffer(input logic with_eob);
		byte_req_t req;
		for (int i = 0; i < buf_bytes.size(); i++) begin
			req.in_byte = buf_bytes[i];
			req.end_of_buffer = with_eob && (i == buf_bytes.size() - 1);
			send_byte(req, 1'b0, NO_LABEL);
		end
	endtask

	// Drain every outstanding label, then change mode; the parser restarts.
	task automatic write_mode(input logic v);
		byte_valid <= 1'b0;
		while (pending_labels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sig_mode = v;
		restart_parse();
	endtask

	task automatic add_noise(input int n);
		repeat (n) buf_bytes = {buf_bytes, 8'($urandom)};
	endtask

	// Encode a count, sometimes with needless continuation bytes.
	task automatic add_count(input int unsigned v);
		int         nbytes;
		logic [7:0] chunk;
		count_spots = {count_spots, buf_bytes.size()};
		nbytes = (v < 128) ? 1 : (v < 16384) ? 2 : 3;
		if (nbytes < 3 && $urandom_range(0, 5) == 0) nbytes++;
		for (int i = 0; i < nbytes; i++) begin
			chunk = (i < 2) ? 8'((v >> (7 * i)) & 32'h7F) : 8'(v >> 14);
			if (i < nbytes - 1) chunk = chunk | VARINT_MORE;
			buf_bytes = {buf_bytes, chunk};
		end
	endtask

	task automatic trim_to(input int len);
		while (buf_bytes.size() > len) void'(buf_bytes.pop_back());
	endtask

	task automatic build_message();
		int n;
		int accts;
		int dlen;
		buf_bytes.delete();
		count_spots.delete();
		if (sig_mode) begin
			n = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(0, 1);
			add_count(n);
			add_noise(n * SIG_BYTES);
		end
		add_noise(3);
		n = ($urandom_range(0, 4) == 0) ? 2 : $urandom_range(0, 1);
		add_count(n);
		add_noise(n * KEY_BYTES + KEY_BYTES);
		n = $urandom_range(0, 3);
		add_count(n);
		repeat (n) begin
			add_noise(1);
			accts = $urandom_range(0, 5);
			add_count(accts);
			add_noise(accts);
			dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(120, 200) : $urandom_range(0, 8);
			add_count(dlen);
			add_noise(dlen);
		end
	endtask

	task automatic send_random_buffer();
		int sel;
		sel = $urandom_range(0, 99);
		build_message();
		if (sel < 60) begin
			add_noise($urandom_range(0, 3));
		end else if (sel < 75) begin
			trim_to($urandom_range(1, buf_bytes.size()));
		end else if (sel < 85) begin
			trim_to(count_spots[$urandom_range(0, count_spots.size() - 1)]);
			buf_bytes = {buf_bytes, VARINT_MORE | 8'($urandom_range(0, 127))};
			buf_bytes = {buf_bytes, VARINT_MORE | 8'($urandom_range(0, 127))};
			buf_bytes = {buf_bytes, 8'($urandom_range(4, 255))};
			add_noise($urandom_range(0, 5));
		end else if (sel < 93) begin
			buf_bytes.delete();
			add_noise($urandom_range(1, 24));
		end else begin
			// huge count in three bytes, then give up early
			trim_to(count_spots[$urandom_range(0, count_spots.size() - 1)]);
			add_count($urandom_range(16384, 65535));
			add_noise($urandom_range(0, 20));
		end
		send_buffer(1'b1);
	endtask

	task automatic report(input string field, input logic [15:0] want, input logic [15:0] got);
		mismatches++;
		$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
	endtask

	always @(posedge clk) begin
		label_req_t want;
		if (arst_n && label_valid && !label_stall) begin
			if (pending_labels.size() == 0) begin
				mismatches++;
				$display("%0t: label with nothing expected, got %h", $time, label_data);
			end else begin
				want = pending_labels.pop_front();
				if (label_data.byte_kind !== want.byte_kind)
					report("byte_kind", 16'(want.byte_kind), 16'(label_data.byte_kind));
				if (label_data.item_number !== want.item_number)
					report("item_number", want.item_number, label_data.item_number);
				if (label_data.byte_offset !== want.byte_offset)
					report("byte_offset", want.byte_offset, label_data.byte_offset);
				if (label_data.count_value !== want.count_value)
					report("count_value", want.count_value, label_data.count_value);
				if (label_data.count_valid !== want.count_valid)
					report("count_valid", 16'(want.count_valid), 16'(label_data.count_valid));
				if (label_data.status !== want.status)
					report("status", 16'(want.status), 16'(label_data.status));
				if (label_data.message_done !== want.message_done)
					report("message_done", 16'(want.message_done), 16'(label_data.message_done));
			end
		end
	end

	// Receiver: runs of stall and flow at a changing rate, plus one long hold on request.
	initial begin
		int   run_left;
		int   rate_left;
		int   pct;
		int   hold_left;
		logic stall_now;
		run_left = 0;
		rate_left = 0;
		pct = 0;
		hold_left = 0;
		stall_now = 1'b0;
		label_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				label_stall <= 1'b1;
			end else begin
				if (rate_left == 0) begin
					rate_left = $urandom_range(50, 300);
					case ($urandom_range(0, 4))
						0, 1: pct = 0;
						2: pct = 25;
						3: pct = 50;
						default: pct = 85;
					endcase
				end
				rate_left--;
				if (run_left == 0) begin
					run_left = $urandom_range(1, 6);
					stall_now = $urandom_range(0, 99) < pct;
				end
				run_left--;
				label_stall <= stall_now;
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		byte_req_t req;
		int        phase_start;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		hold_req = 1'b0;
		gaps_on = 1'b1;
		burst_left = 0;
		mismatches = 0;
		items_sent = 0;
		sig_mode = 1'b1;
		restart_parse();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				write_mode(DIRECTED[i].value[0]);
			end else begin
				req.in_byte = DIRECTED[i].value;
				req.end_of_buffer = DIRECTED[i].last;
				send_byte(req, DIRECTED[i].typed, DIRECTED[i].label);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0, 3: write_mode(1'b0);
				1, 2: write_mode(1'b1);
				default: write_mode(1'($urandom_range(0, 1)));
			endcase
			gaps_on = !(p == 2 || p == 3);
			// keep offering while the receiver holds off
			if (p == 3) hold_req = 1'b1;
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_BYTES) send_random_buffer();
			// sometimes leave a buffer open so the next mode write aborts it
			if ($urandom_range(0, 1) == 1) begin
				build_message();
				trim_to($urandom_range(1, buf_bytes.size()));
				send_buffer(1'b0);
			end
		end

		byte_valid <= 1'b0;
		while (pending_labels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule
